/* sv/rap_pkg.sv */
// Package: shared types and constants of the RADIUS attribute parser.
package rap_pkg;

  localparam int unsigned HdrBytes    = 20;
  localparam int unsigned LenOverhead = 2;
  localparam int unsigned HdrCntW     = 5;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_STOP   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] attr_type;
    logic [7:0] value_length;
    logic [7:0] value_index;
    logic [7:0] value_byte;
    logic       last_of_attr;
    logic       truncated;
  } result_t;

  typedef struct packed {
    phase_t               phase;
    logic [HdrCntW-1:0]   header_count;
  } status_t;

endpackage

/* sv/radius_attribute_parser_unit.sv */
// Top level: RADIUS attribute parser, one packet byte in, one value byte out.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | data_byte, end_of_packet
//  out     | out_valid / out_stall | attr_type, value_length, value_index,
//          |                       | value_byte, last_of_attr, truncated
//
// One byte per cycle while in_stall is low; a value byte's result is registered,
// out in the cycle after accept. The single result register sets the rate:
// in_stall is high only while it holds a result that the sink stalls.
// rst is synchronous; it clears the parse state and empties the result register.
module radius_attribute_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_packet,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] attr_type,
  output logic [7:0] value_length,
  output logic [7:0] value_index,
  output logic [7:0] value_byte,
  output logic       last_of_attr,
  output logic       truncated
);
  import rap_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res_comb;
  result_t res_q;
  status_t status;

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  rap_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (in_fire),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .res_valid     (res_valid),
    .res           (res_comb),
    .status        (status)
  );

  rap_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire),
    .load_valid (res_valid),
    .load_res   (res_comb),
    .take       (!out_stall),
    .full       (out_valid),
    .res        (res_q)
  );

  assign attr_type    = res_q.attr_type;
  assign value_length = res_q.value_length;
  assign value_index  = res_q.value_index;
  assign value_byte   = res_q.value_byte;
  assign last_of_attr = res_q.last_of_attr;
  assign truncated    = res_q.truncated;

  a_trunc_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(truncated && last_of_attr))
    else $error("truncated and last_of_attr both set");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_attr) |-> ({1'b0, value_index} + 9'd1 == {1'b0, value_length}))
    else $error("last_of_attr on wrong value index");

  a_eop_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_of_packet) |=> (status.phase == PH_HEADER && status.header_count == '0))
    else $error("parser did not restart after packet end");

  a_hdr_bound: assert property (@(posedge clk) disable iff (rst)
    (status.phase == PH_HEADER) |-> (status.header_count < HdrCntW'(HdrBytes)))
    else $error("header count overran");

endmodule

/* sv/rap_parser.sv */
// Parse state machine: header skip, TLV tracking and per-byte result build.
module rap_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             end_of_packet,
  output logic             res_valid,
  output rap_pkg::result_t res,
  output rap_pkg::status_t status
);
  import rap_pkg::*;

  phase_t             phase, phase_next;
  logic [HdrCntW-1:0] header_count, header_count_next;
  logic [7:0]         cur_type, cur_type_next;
  logic [7:0]         cur_length, cur_length_next;
  logic [7:0]         cur_index, cur_index_next;
  logic               last;
  logic [HdrCntW-1:0] hdr_inc;

  assign hdr_inc = header_count + HdrCntW'(1);
  assign last    = ({1'b0, cur_index} + 9'd1) >= {1'b0, cur_length};

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    cur_type_next     = cur_type;
    cur_length_next   = cur_length;
    cur_index_next    = cur_index;
    res_valid         = 1'b0;
    res.attr_type     = cur_type;
    res.value_length  = cur_length;
    res.value_index   = cur_index;
    res.value_byte    = data_byte;
    res.last_of_attr  = last;
    res.truncated     = end_of_packet && !last;
    unique case (phase)
      PH_HEADER: begin
        header_count_next = hdr_inc;
        if (hdr_inc >= HdrCntW'(HdrBytes)) phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        cur_type_next = data_byte;
        phase_next    = PH_LEN;
      end
      PH_LEN: begin
        if (data_byte <= 8'(LenOverhead)) begin
          phase_next = PH_STOP;
        end else begin
          cur_length_next = data_byte - 8'(LenOverhead);
          cur_index_next  = '0;
          phase_next      = PH_VALUE;
        end
      end
      PH_VALUE: begin
        res_valid      = 1'b1;
        cur_index_next = cur_index + 8'd1;
        if (last) phase_next = PH_TYPE;
      end
      default: phase_next = PH_STOP;
    endcase
    if (end_of_packet) begin
      phase_next        = PH_HEADER;
      header_count_next = '0;
      cur_type_next     = '0;
      cur_length_next   = '0;
      cur_index_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      cur_type     <= '0;
      cur_length   <= '0;
      cur_index    <= '0;
    end else if (step) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      cur_type     <= cur_type_next;
      cur_length   <= cur_length_next;
      cur_index    <= cur_index_next;
    end
  end

  assign status.phase        = phase;
  assign status.header_count = header_count;

endmodule

/* sv/rap_out_reg.sv */
// Result register: holds one result transaction until the sink takes it.
module rap_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             load_valid,
  input  rap_pkg::result_t load_res,
  input  logic             take,
  output logic             full,
  output rap_pkg::result_t res
);
  import rap_pkg::*;

  logic full_next;

  always_comb begin
    full_next = full;
    if (load)      full_next = load_valid;
    else if (take) full_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) full <= 1'b0;
    else     full <= full_next;
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) res <= load_res;
  end

endmodule

/* sim/radius_attribute_parser_unit_tb.sv */
// Testbench for the RADIUS attribute parser: directed and random packets checked against a byte-level parse.
`timescale 1ns / 100ps

module radius_attribute_parser_unit_tb;
  import rap_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eop;
  } pkt_byte_t;

  typedef enum int {
    SH_FULL, SH_CUT_VALUE, SH_CUT_TYPE, SH_CUT_LEN, SH_STOP, SH_SHORT, SH_NOISE
  } pkt_shape_t;

  localparam int RandBytes = 850;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_packet = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] attr_type;
  logic [7:0] value_length;
  logic [7:0] value_index;
  logic [7:0] value_byte;
  logic       last_of_attr;
  logic       truncated;

  radius_attribute_parser_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_packet(end_of_packet),
    .out_valid(out_valid), .out_stall(out_stall),
    .attr_type(attr_type), .value_length(value_length), .value_index(value_index),
    .value_byte(value_byte), .last_of_attr(last_of_attr), .truncated(truncated)
  );

  pkt_byte_t   bytes_to_send[$];
  result_t     value_bytes_due[$];

  phase_t      parse_phase;
  logic [4:0]  hdr_seen;
  logic [7:0]  attr_type_now;
  logic [7:0]  value_len_now;
  logic [7:0]  value_idx_now;

  int n_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_trunc = 0;
  int n_packets = 0;
  int n_fail = 0;
  int quiet_after = 32'h7fffffff;
  int send_gap = 0;
  int stall_left = 0;
  bit in_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic clear_parse();
    parse_phase   = PH_HEADER;
    hdr_seen      = '0;
    attr_type_now = '0;
    value_len_now = '0;
    value_idx_now = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    result_t r;
    logic    at_end;
    case (parse_phase)
      PH_HEADER: begin
        hdr_seen = hdr_seen + 5'd1;
        if (hdr_seen >= HdrBytes) parse_phase = PH_TYPE;
      end
      PH_TYPE: begin
        attr_type_now = b;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b <= LenOverhead) begin
          parse_phase = PH_STOP;
        end else begin
          value_len_now = b - 8'(LenOverhead);
          value_idx_now = '0;
          parse_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        at_end = ({1'b0, value_idx_now} + 9'd1) >= {1'b0, value_len_now};
        r.attr_type    = attr_type_now;
        r.value_length = value_len_now;
        r.value_index  = value_idx_now;
        r.value_byte   = b;
        r.last_of_attr = at_end;
        r.truncated    = eop && !at_end;
        value_bytes_due.push_back(r);
        value_idx_now = value_idx_now + 8'd1;
        if (at_end) parse_phase = PH_TYPE;
      end
      default: parse_phase = PH_STOP;
    endcase
    if (eop) clear_parse();
  endtask

  task automatic check_value_byte();
    result_t e;
    if (value_bytes_due.size() == 0) begin
      $error("unexpected transaction: value_byte %0d", value_byte);
      n_fail++;
      return;
    end
    e = value_bytes_due.pop_front();
    n_checked++;
    if (truncated === 1'b1) n_trunc++;
    if (attr_type !== e.attr_type) begin
      $error("attr_type: expected %0d, got %0d", e.attr_type, attr_type);
      n_fail++;
    end
    if (value_length !== e.value_length) begin
      $error("value_length: expected %0d, got %0d", e.value_length, value_length);
      n_fail++;
    end
    if (value_index !== e.value_index) begin
      $error("value_index: expected %0d, got %0d", e.value_index, value_index);
      n_fail++;
    end
    if (value_byte !== e.value_byte) begin
      $error("value_byte: expected %0d, got %0d", e.value_byte, value_byte);
      n_fail++;
    end
    if (last_of_attr !== e.last_of_attr) begin
      $error("last_of_attr: expected %0d, got %0d", e.last_of_attr, last_of_attr);
      n_fail++;
    end
    if (truncated !== e.truncated) begin
      $error("truncated: expected %0d, got %0d", e.truncated, truncated);
      n_fail++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) check_value_byte();
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        n_taken++;
        parse_byte(data_byte, end_of_packet);
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    pkt_byte_t nb;
    if (!rst && (!in_valid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        nb = bytes_to_send.pop_front();
        in_valid      <= 1'b1;
        data_byte     <= nb.data;
        end_of_packet <= nb.eop;
        if (n_taken < quiet_after && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink stall
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (n_taken < quiet_after && $urandom_range(0, 6) == 0)
        stall_left = $urandom_range(1, 5);
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eop);
    pkt_byte_t t;
    t.data = b;
    t.eop  = eop;
    bytes_to_send.push_back(t);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || value_bytes_due.size() != 0) @(negedge clk);
  endtask

  task automatic gen_packet(input pkt_shape_t shape, input bit big_first);
    int n_attr;
    int len_b;
    int cut;
    int trail;
    bit final_attr;
    n_packets++;
    if (shape == SH_NOISE) begin
      cut = $urandom_range(1, 40);
      for (int i = 0; i < cut; i++) add_byte(8'($urandom_range(0, 255)), i == cut - 1);
      return;
    end
    if (shape == SH_SHORT) begin
      cut = $urandom_range(1, HdrBytes);
      for (int i = 0; i < cut; i++) add_byte(8'($urandom_range(0, 255)), i == cut - 1);
      return;
    end
    for (int i = 0; i < HdrBytes; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    n_attr = $urandom_range(1, 4);
    for (int a = 0; a < n_attr; a++) begin
      final_attr = (a == n_attr - 1);
      if (final_attr && shape == SH_CUT_TYPE) begin
        add_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
      add_byte(8'($urandom_range(0, 255)), 1'b0);
      if (final_attr && shape == SH_STOP) begin
        trail = $urandom_range(0, 5);
        add_byte(8'($urandom_range(0, LenOverhead)), trail == 0);
        for (int i = 0; i < trail; i++)
          add_byte(8'($urandom_range(0, 255)), i == trail - 1);
        return;
      end
      if (big_first && a == 0) len_b = 255;
      else if ($urandom_range(0, 9) < 7) len_b = $urandom_range(3, 10);
      else len_b = $urandom_range(11, 40);
      if (final_attr && shape == SH_CUT_VALUE && len_b == 3) len_b = 4;
      if (final_attr && shape == SH_CUT_LEN) begin
        add_byte(8'(len_b), 1'b1);
        return;
      end
      add_byte(8'(len_b), 1'b0);
      cut = len_b - LenOverhead;
      if (final_attr && shape == SH_CUT_VALUE) cut = $urandom_range(1, cut - 1);
      for (int i = 0; i < cut; i++)
        add_byte(8'($urandom_range(0, 255)), final_attr && (i == cut - 1));
    end
  endtask

  initial begin
    int pkt;
    int pick;
    int stop_at;
    pkt_shape_t shape;
    clear_parse();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one-byte packet, then a packet with a one-byte attribute value and a stop length
    add_byte(8'hFF, 1'b1);
    for (int i = 0; i < HdrBytes; i++) add_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'd3, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'd2, 1'b0);
    add_byte(8'hFF, 1'b1);
    n_packets += 2;
    wait_drained();

    stop_at = n_queued + RandBytes;
    quiet_after = n_queued + 720;
    pkt = 0;
    while (n_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pkt < 6) shape = pkt_shape_t'(pkt);
      else if (pkt == 6) shape = SH_FULL;
      else if (pick < 45) shape = SH_FULL;
      else if (pick < 60) shape = SH_CUT_VALUE;
      else if (pick < 68) shape = SH_CUT_TYPE;
      else if (pick < 76) shape = SH_CUT_LEN;
      else if (pick < 86) shape = SH_STOP;
      else if (pick < 92) shape = SH_SHORT;
      else shape = SH_NOISE;
      gen_packet(shape, pkt == 6);
      if (pkt == 15) wait_drained();
      pkt++;
    end

    wait_drained();
    repeat (5) @(negedge clk);
    $display("Parsed %0d packets, %0d bytes in; %0d value bytes checked, %0d cut short.",
             n_packets, n_taken, n_checked, n_trunc);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
